// ----- rtl/ewma_cost_estimator_table_defines.svh -----
// assertion macros for the duration cost estimator table
`ifndef EWMA_COST_ESTIMATOR_TABLE_DEFINES_SVH
`define EWMA_COST_ESTIMATOR_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ECET_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ecet assertion failed");
// next-cycle implication
`define ECET_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ecet assertion failed");
`else
`define ECET_ASSERT_IMP(label, clk, rst, ante, cons)
`define ECET_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/ecet_pkg.sv -----
// shared types, widths and constants of the duration cost estimator table
package ecet_pkg;

  localparam int DATA_W       = 48;
  localparam int FRAC_W       = 8;
  localparam int FIX_W        = 56;
  localparam int CNT_W        = 32;
  localparam int ALPHA_W      = 16;
  localparam int CT_CODE_W    = 4;
  localparam int TI_W         = 6;
  localparam int CT_IDX_MAX_W = 8;
  localparam int SLOT_MAX_W   = 20;

  localparam int COMPONENT_TYPES_DEF    = 16;
  localparam int TEMPLATES_PER_TYPE_DEF = 64;

  localparam logic [DATA_W-1:0]  COLD_START_RESET = 48'd5000000;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET      = 16'd19661;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLD_START = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = CFG_IDX_W'(1);

  localparam logic ACT_RECORD = 1'b0;

  typedef struct packed {
    logic                     action;
    logic [CT_CODE_W-1:0]     component_type;
    logic                     has_template;
    logic [TI_W-1:0]          template_index;
    logic signed [DATA_W-1:0] duration_ns;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] estimate_ns;
    logic [CNT_W-1:0]  template_count;
    logic [CNT_W-1:0]  component_count;
  } out_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]  cold_start_ns;
    logic [ALPHA_W-1:0] alpha_q16;
  } cfg_t;

  // classified item as it waits between front and back
  typedef struct packed {
    logic                    is_record;
    logic                    has_tpl;
    logic [CT_IDX_MAX_W-1:0] agg_idx;
    logic [SLOT_MAX_W-1:0]   slot;
    logic [FIX_W-1:0]        x;
  } job_t;

  typedef struct packed {
    logic [FIX_W-1:0] mean;
    logic [FIX_W-1:0] dev;
    logic [CNT_W-1:0] cnt;
  } bucket_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_MAG,
    ST_DMAG,
    ST_MUL,
    ST_APPLY,
    ST_COMPOSE
  } back_state_t;

endpackage

// ----- rtl/ecet_front.sv -----
// front end: accepts words, maps keys to table indices and queues them
module ecet_front #(
  parameter int COMPONENT_TYPES    = ecet_pkg::COMPONENT_TYPES_DEF,
  parameter int TEMPLATES_PER_TYPE = ecet_pkg::TEMPLATES_PER_TYPE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  ecet_pkg::in_item_t item,
  input  logic               clear_done,
  output logic               job_valid,
  input  logic               job_ready,
  output ecet_pkg::job_t     job
);

  localparam int TDEPTH    = COMPONENT_TYPES * TEMPLATES_PER_TYPE;
  localparam int SLOT_W    = TDEPTH > 1 ? $clog2(TDEPTH) : 1;
  localparam int CT_W      = COMPONENT_TYPES > 1 ? $clog2(COMPONENT_TYPES) : 1;
  localparam int TPL_W     = TEMPLATES_PER_TYPE > 1 ? $clog2(TEMPLATES_PER_TYPE) : 1;
  localparam int CT_CODE_W = ecet_pkg::CT_CODE_W;
  localparam int TI_W      = ecet_pkg::TI_W;
  localparam int QPTR_W    = ecet_pkg::QPTR_W;
  localparam int QCNT_W    = ecet_pkg::QCNT_W;
  localparam int FIX_W     = ecet_pkg::FIX_W;
  localparam int DATA_W    = ecet_pkg::DATA_W;
  localparam int FRAC_W    = ecet_pkg::FRAC_W;

  logic [CT_W-1:0]   ct_m;
  logic [TPL_W-1:0]  ti_m;
  logic [SLOT_W-1:0] slot;
  ecet_pkg::job_t    cls;

  ecet_pkg::job_t    q [ecet_pkg::QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  // key wrap as constant lookup over every input code
  always_comb begin
    ct_m = '0;
    for (int i = 0; i < 2**CT_CODE_W; i++) begin
      if (item.component_type == CT_CODE_W'(i)) ct_m = CT_W'(i % COMPONENT_TYPES);
    end
  end

  always_comb begin
    ti_m = '0;
    for (int i = 0; i < 2**TI_W; i++) begin
      if (item.template_index == TI_W'(i)) ti_m = TPL_W'(i % TEMPLATES_PER_TYPE);
    end
  end

  assign slot = SLOT_W'(ct_m) * SLOT_W'(TEMPLATES_PER_TYPE) + SLOT_W'(ti_m);

  always_comb begin
    cls.is_record = (item.action == ecet_pkg::ACT_RECORD) && !item.duration_ns[DATA_W-1];
    cls.has_tpl   = item.has_template;
    cls.agg_idx   = ecet_pkg::CT_IDX_MAX_W'(ct_m);
    cls.slot      = ecet_pkg::SLOT_MAX_W'(slot);
    cls.x         = FIX_W'({item.duration_ns[DATA_W-2:0], {FRAC_W{1'b0}}});
  end

  assign item_ready = clear_done && (count != QCNT_W'(ecet_pkg::QUEUE_DEPTH));
  assign push       = item_valid && item_ready;
  assign job_valid  = (count != '0);
  assign pop        = job_valid && job_ready;
  assign job        = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(ecet_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(ecet_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/ecet_back.sv -----
// back end: bucket tables, shared update datapath and result register
`include "ewma_cost_estimator_table_defines.svh"

module ecet_back #(
  parameter int COMPONENT_TYPES    = ecet_pkg::COMPONENT_TYPES_DEF,
  parameter int TEMPLATES_PER_TYPE = ecet_pkg::TEMPLATES_PER_TYPE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ecet_pkg::cfg_t      cfg,
  input  logic                job_valid,
  output logic                job_ready,
  input  ecet_pkg::job_t      job_in,
  output logic                clear_done,
  output logic                result_valid,
  input  logic                result_ready,
  output ecet_pkg::out_item_t result
);

  localparam int TDEPTH  = COMPONENT_TYPES * TEMPLATES_PER_TYPE;
  localparam int SLOT_W  = TDEPTH > 1 ? $clog2(TDEPTH) : 1;
  localparam int CT_W    = COMPONENT_TYPES > 1 ? $clog2(COMPONENT_TYPES) : 1;
  localparam int FIX_W   = ecet_pkg::FIX_W;
  localparam int CNT_W   = ecet_pkg::CNT_W;
  localparam int DATA_W  = ecet_pkg::DATA_W;
  localparam int FRAC_W  = ecet_pkg::FRAC_W;
  localparam int ALPHA_W = ecet_pkg::ALPHA_W;
  localparam int PROD_W  = FIX_W + ALPHA_W;

  ecet_pkg::back_state_t state;
  ecet_pkg::back_state_t state_next;

  ecet_pkg::bucket_t tmem [TDEPTH];
  ecet_pkg::bucket_t amem [COMPONENT_TYPES];
  ecet_pkg::bucket_t t_rd;
  ecet_pkg::bucket_t a_rd;
  ecet_pkg::bucket_t w;
  ecet_pkg::bucket_t nb;
  ecet_pkg::bucket_t t_fin;
  ecet_pkg::bucket_t a_fin;
  ecet_pkg::bucket_t sel;
  ecet_pkg::bucket_t wdata;
  ecet_pkg::job_t    job;

  logic [SLOT_W-1:0] clr_cnt;
  logic              clr_wr;
  logic              clr_in_agg;
  logic              t_we;
  logic              a_we;
  logic [SLOT_W-1:0] t_waddr;
  logic [CT_W-1:0]   a_waddr;
  logic              out_load;
  logic              pass;
  logic              mean_up;
  logic              dev_up;
  logic [FIX_W-1:0]  mag;
  logic [FIX_W-1:0]  dmag;
  logic [FIX_W-1:0]  pa;
  logic [FIX_W-1:0]  pb;
  logic [PROD_W-1:0] prod_a;
  logic [PROD_W-1:0] prod_b;
  logic              has_sel;
  logic [FIX_W:0]    sum;
  logic [DATA_W-1:0] est_raw;
  logic [DATA_W-1:0] est;

  // sequencer
  always_comb begin
    state_next = state;
    job_ready  = 1'b0;
    clr_wr     = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ecet_pkg::ST_CLEAR: begin
        clr_wr = 1'b1;
        if (clr_cnt == SLOT_W'(TDEPTH - 1)) state_next = ecet_pkg::ST_IDLE;
      end
      ecet_pkg::ST_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) state_next = ecet_pkg::ST_READ;
      end
      ecet_pkg::ST_READ:  state_next = ecet_pkg::ST_LOAD;
      ecet_pkg::ST_LOAD:  state_next = job.is_record ? ecet_pkg::ST_MAG : ecet_pkg::ST_COMPOSE;
      ecet_pkg::ST_MAG:   state_next = ecet_pkg::ST_DMAG;
      ecet_pkg::ST_DMAG:  state_next = ecet_pkg::ST_MUL;
      ecet_pkg::ST_MUL:   state_next = ecet_pkg::ST_APPLY;
      ecet_pkg::ST_APPLY: state_next = pass ? ecet_pkg::ST_COMPOSE : ecet_pkg::ST_MAG;
      ecet_pkg::ST_COMPOSE: begin
        if (!result_valid || result_ready) begin
          out_load   = 1'b1;
          state_next = ecet_pkg::ST_IDLE;
        end
      end
      default: state_next = ecet_pkg::ST_CLEAR;
    endcase
  end

  assign clear_done = (state != ecet_pkg::ST_CLEAR);
  assign clr_in_agg = ((SLOT_W + 1)'(clr_cnt) < (SLOT_W + 1)'(COMPONENT_TYPES));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ecet_pkg::ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (clr_wr) clr_cnt <= clr_cnt + SLOT_W'(1);
    end
  end

  // first pass: template bucket, or aggregate if none; second pass: aggregate
  assign t_we = clr_wr || (state == ecet_pkg::ST_APPLY && !pass && job.has_tpl);
  assign a_we = (clr_wr && clr_in_agg) ||
                (state == ecet_pkg::ST_APPLY && (pass || !job.has_tpl));
  assign t_waddr = clr_wr ? clr_cnt : job.slot[SLOT_W-1:0];
  assign a_waddr = clr_wr ? clr_cnt[CT_W-1:0] : job.agg_idx[CT_W-1:0];
  assign wdata   = clr_wr ? '0 : nb;

  always_ff @(posedge clk) begin
    if (t_we) tmem[t_waddr] <= wdata;
    t_rd <= tmem[job.slot[SLOT_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (a_we) amem[a_waddr] <= wdata;
    a_rd <= amem[job.agg_idx[CT_W-1:0]];
  end

  assign prod_a = PROD_W'(mag) * PROD_W'(cfg.alpha_q16);
  assign prod_b = PROD_W'(dmag) * PROD_W'(cfg.alpha_q16);

  always_comb begin
    if (w.cnt == '0) begin
      nb.mean = job.x;
      nb.dev  = '0;
    end else begin
      nb.mean = mean_up ? w.mean + pa : w.mean - pa;
      nb.dev  = dev_up ? w.dev + pb : w.dev - pb;
    end
    nb.cnt = (w.cnt == '1) ? w.cnt : w.cnt + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ecet_pkg::ST_IDLE: begin
        if (job_valid) job <= job_in;
      end
      ecet_pkg::ST_LOAD: begin
        pass  <= 1'b0;
        t_fin <= job.has_tpl ? t_rd : a_rd;
        a_fin <= a_rd;
        w     <= job.has_tpl ? t_rd : a_rd;
      end
      ecet_pkg::ST_MAG: begin
        mean_up <= (job.x >= w.mean);
        mag     <= (job.x >= w.mean) ? job.x - w.mean : w.mean - job.x;
      end
      ecet_pkg::ST_DMAG: begin
        dev_up <= (mag >= w.dev);
        dmag   <= (mag >= w.dev) ? mag - w.dev : w.dev - mag;
      end
      ecet_pkg::ST_MUL: begin
        pa <= prod_a[PROD_W-1:ALPHA_W];
        pb <= prod_b[PROD_W-1:ALPHA_W];
      end
      ecet_pkg::ST_APPLY: begin
        if (!pass) begin
          t_fin <= nb;
          // without a template the aggregate is updated again from its new value
          w     <= job.has_tpl ? a_rd : nb;
          pass  <= 1'b1;
        end else begin
          a_fin <= nb;
          if (!job.has_tpl) t_fin <= nb;
        end
      end
      default: ;
    endcase
  end

  // estimate from template bucket, else aggregate, else cold start
  always_comb begin
    has_sel = 1'b1;
    if (t_fin.cnt != '0) begin
      sel = t_fin;
    end else if (a_fin.cnt != '0) begin
      sel = a_fin;
    end else begin
      sel     = a_fin;
      has_sel = 1'b0;
    end
    sum     = (FIX_W + 1)'(sel.mean) + (FIX_W + 1)'(sel.dev);
    est_raw = has_sel ? sum[FIX_W-1:FRAC_W] : cfg.cold_start_ns;
    est     = (est_raw == '0) ? DATA_W'(1) : est_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.estimate_ns     <= est;
      result.template_count  <= t_fin.cnt;
      result.component_count <= a_fin.cnt;
    end
  end

  `ECET_ASSERT_IMP(a_est_nonzero, clk, rst, result_valid, result.estimate_ns != '0)
  `ECET_ASSERT_NXT(a_rec_counted, clk, rst, out_load && job.is_record, result.component_count != '0)
  `ECET_ASSERT_NXT(a_agg_alias, clk, rst, out_load && !job.has_tpl, result.template_count == result.component_count)
  `ECET_ASSERT_IMP(a_one_table_write, clk, rst, state == ecet_pkg::ST_APPLY, t_we != a_we)

endmodule

// ----- rtl/ewma_cost_estimator_table.sv -----
// top level of the duration cost estimator table: config registers, front and back
// query: queue, then IDLE, READ, LOAD, COMPOSE; the back end takes one job at a time
// record: two bucket updates, each by MAG, DMAG, MUL, APPLY, in one shared datapath
// input words queue two deep while the back end is busy or the result is held
// after reset the tables are swept to zero, COMPONENT_TYPES * TEMPLATES_PER_TYPE slots
// (1024 by default) with item_ready low; config registers reset to their defaults
module ewma_cost_estimator_table #(
  parameter int COMPONENT_TYPES    = ecet_pkg::COMPONENT_TYPES_DEF,
  parameter int TEMPLATES_PER_TYPE = ecet_pkg::TEMPLATES_PER_TYPE_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  ecet_pkg::in_item_t               item,
  output logic                             result_valid,
  input  logic                             result_ready,
  output ecet_pkg::out_item_t              result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ecet_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ecet_pkg::DATA_W-1:0]      cfg_data
);

  localparam int ALPHA_W = ecet_pkg::ALPHA_W;

  ecet_pkg::cfg_t cfg;
  ecet_pkg::job_t job;
  logic           job_valid;
  logic           job_ready;
  logic           clear_done;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cold_start_ns <= ecet_pkg::COLD_START_RESET;
      cfg.alpha_q16     <= ecet_pkg::ALPHA_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ecet_pkg::CFG_COLD_START: cfg.cold_start_ns <= cfg_data;
        ecet_pkg::CFG_ALPHA:      cfg.alpha_q16     <= cfg_data[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  ecet_front #(
    .COMPONENT_TYPES    (COMPONENT_TYPES),
    .TEMPLATES_PER_TYPE (TEMPLATES_PER_TYPE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .clear_done (clear_done),
    .job_valid  (job_valid),
    .job_ready  (job_ready),
    .job        (job)
  );

  ecet_back #(
    .COMPONENT_TYPES    (COMPONENT_TYPES),
    .TEMPLATES_PER_TYPE (TEMPLATES_PER_TYPE)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .job_valid    (job_valid),
    .job_ready    (job_ready),
    .job_in       (job),
    .clear_done   (clear_done),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
